// ===== rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i; ASSERT_CLK is quiet in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property that must hold at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/modexp_pkg.sv =====
// -----------------------------------------------------------------------------
// Modular exponentiation package
// Default width, FSM state type and controller/datapath command and status.
// -----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  // Default operand width
  localparam int unsigned DefaultWidth = 32;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_RED_END,
    ST_MUL_LOAD,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_MUL_END,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture a new input word
    logic init_red;    // clear accumulator, seed result with 1 mod m
    logic red_step;    // one shift-subtract step of base reduction
    logic base_store;  // keep the reduced base
    logic mul_load;    // set up a modular product
    logic sel_base;    // multiplier operand is the base, else the result
    logic dbl_step;    // accumulator doubling mod m
    logic add_step;    // conditional add of multiplicand mod m
    logic res_store;   // product becomes the running result
    logic exp_shift;   // move to next exponent bit
    logic set_one;     // zero exponent: result is one
    logic set_bad;     // zero modulus: result zero, flag raised
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_bit;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/modexp_dp.sv =====
// -----------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand registers and one shared modular add unit (x + y + cin mod m).
// -----------------------------------------------------------------------------
`default_nettype none

module modexp_dp #(
  parameter int unsigned WIDTH = modexp_pkg::DefaultWidth
) (
  input  wire logic               clk_i,
  input  wire modexp_pkg::cmd_t   cmd_i,
  output modexp_pkg::status_t     status_o,
  input  wire logic [WIDTH-1:0]   base_i,
  input  wire logic [WIDTH-1:0]   exponent_i,
  input  wire logic [WIDTH-1:0]   modulus_i,
  output logic      [WIDTH-1:0]   result_o,
  output logic                    bad_modulus_o
);
  import modexp_pkg::*;

  logic [WIDTH-1:0] base_q, exp_q, mod_q, res_q, acc_q, mcand_q, mplier_q;
  logic             bad_q;

  logic [WIDTH-1:0] add_y;
  logic             add_cin;
  logic [WIDTH:0]   add_sum;
  logic [WIDTH:0]   add_red;
  logic             add_en;

  // Shared modular adder: both operands below m, so one subtract suffices
  assign add_y   = cmd_i.add_step ? mcand_q : acc_q;
  assign add_cin = cmd_i.red_step & base_q[WIDTH-1];
  assign add_sum = {1'b0, acc_q} + {1'b0, add_y} + {{WIDTH{1'b0}}, add_cin};
  assign add_red = (add_sum >= {1'b0, mod_q}) ? (add_sum - {1'b0, mod_q}) : add_sum;
  assign add_en  = cmd_i.red_step | cmd_i.dbl_step | (cmd_i.add_step & mplier_q[WIDTH-1]);

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
      exp_q  <= exponent_i;
      mod_q  <= modulus_i;
      bad_q  <= 1'b0;
    end else begin
      if (cmd_i.red_step)   base_q <= {base_q[WIDTH-2:0], 1'b0};
      if (cmd_i.base_store) base_q <= acc_q;
      if (cmd_i.exp_shift)  exp_q  <= {exp_q[WIDTH-2:0], 1'b0};
      if (cmd_i.set_bad)    bad_q  <= 1'b1;
    end

    if (cmd_i.init_red || cmd_i.mul_load) begin
      acc_q <= '0;
    end else if (add_en) begin
      acc_q <= add_red[WIDTH-1:0];
    end

    if (cmd_i.mul_load) begin
      mcand_q  <= res_q;
      mplier_q <= cmd_i.sel_base ? base_q : res_q;
    end else if (cmd_i.add_step) begin
      mplier_q <= {mplier_q[WIDTH-2:0], 1'b0};
    end

    // Running result; 1 mod m is 0 only for m of one
    if (cmd_i.set_bad) begin
      res_q <= '0;
    end else if (cmd_i.set_one) begin
      res_q <= WIDTH'(1);
    end else if (cmd_i.init_red) begin
      res_q <= (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);
    end else if (cmd_i.res_store) begin
      res_q <= acc_q;
    end
  end

  assign status_o.mod_zero = (mod_q == '0);
  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_bit  = exp_q[WIDTH-1];

  assign result_o      = res_q;
  assign bad_modulus_o = bad_q;

endmodule

`default_nettype wire

// ===== rtl/modexp_ctrl.sv =====
// -----------------------------------------------------------------------------
// Modular exponentiation controller
// Checks for a zero modulus or exponent, then sequences base reduction, then square and multiply per exponent bit.
// -----------------------------------------------------------------------------
`default_nettype none

module modexp_ctrl #(
  parameter int unsigned WIDTH = modexp_pkg::DefaultWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  output logic                     valid_o,
  input  wire modexp_pkg::status_t status_i,
  output modexp_pkg::cmd_t         cmd_o
);
  import modexp_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] bit_cnt_q, bit_cnt_d;   // steps within reduction or product
  logic [CntW-1:0] exp_cnt_q, exp_cnt_d;   // exponent bits left
  logic            sq_q, sq_d;             // next product is a squaring

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      exp_cnt_q <= '0;
      sq_q      <= 1'b1;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      exp_cnt_q <= exp_cnt_d;
      sq_q      <= sq_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    exp_cnt_d = exp_cnt_q;
    sq_d      = sq_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.mod_zero) begin
          cmd_o.set_bad = 1'b1;
          state_d       = ST_DONE;
        end else if (status_i.exp_zero) begin
          cmd_o.set_one = 1'b1;
          state_d       = ST_DONE;
        end else begin
          cmd_o.init_red = 1'b1;
          bit_cnt_d      = CntLast;
          state_d        = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = ST_RED_END;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      ST_RED_END: begin
        cmd_o.base_store = 1'b1;
        exp_cnt_d        = CntLast;
        sq_d             = 1'b1;
        state_d          = ST_MUL_LOAD;
      end
      ST_MUL_LOAD: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.sel_base = !sq_q;
        bit_cnt_d      = CntLast;
        state_d        = ST_MUL_DBL;
      end
      ST_MUL_DBL: begin
        cmd_o.dbl_step = 1'b1;
        state_d        = ST_MUL_ADD;
      end
      ST_MUL_ADD: begin
        cmd_o.add_step = 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = ST_MUL_END;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
          state_d   = ST_MUL_DBL;
        end
      end
      ST_MUL_END: begin
        cmd_o.res_store = 1'b1;
        // after a squaring, multiply by the base if the exponent bit is set
        if (sq_q && status_i.exp_bit) begin
          sq_d    = 1'b0;
          state_d = ST_MUL_LOAD;
        end else begin
          cmd_o.exp_shift = 1'b1;
          sq_d            = 1'b1;
          if (exp_cnt_q == '0) begin
            state_d = ST_DONE;
          end else begin
            exp_cnt_d = exp_cnt_q - 1'b1;
            state_d   = ST_MUL_LOAD;
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// -----------------------------------------------------------------------------
// Modular exponentiation
// base ^ exponent mod modulus by square-and-multiply, shift-add products.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake         Ports
// input     in         start & !busy     base_i, exponent_i, modulus_i
// result    out        valid_o strobe    result_o, bad_modulus_o
//
// One word at a time. Zero modulus or zero exponent goes straight to the
// strobe. Otherwise base reduction, then one product per squaring and per
// set exponent bit, then the strobe cycle, all on the one shared modular adder.
// busy stays high until the strobe cycle ends; the result is shown for one
// cycle and cannot be held off. Reset clears the controller only.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modular_exponentiation #(
  parameter int unsigned WIDTH = modexp_pkg::DefaultWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WIDTH-1:0] base_i,
  input  wire logic [WIDTH-1:0] exponent_i,
  input  wire logic [WIDTH-1:0] modulus_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] result_o,
  output logic                  bad_modulus_o
);
  import modexp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  modexp_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .valid_o  (valid_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Operands and modular adder
  modexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .base_i        (base_i),
    .exponent_i    (exponent_i),
    .modulus_i     (modulus_i),
    .result_o      (result_o),
    .bad_modulus_o (bad_modulus_o)
  );

  // Checks
  `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted word did not raise busy")
  `ASSERT_CLK(a_strobe_single, valid_o |=> !valid_o, "result strobe longer than one cycle")
  `ASSERT_CLK(a_strobe_ends, valid_o |=> !busy, "busy still high after result strobe")
  `ASSERT_CLK(a_bad_zero, valid_o && bad_modulus_o |-> result_o == '0, "bad result not zero")

endmodule

`default_nettype wire

// ===== bench/tb_modular_exponentiation.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base/exponent/modulus words through the start/busy handshake, works
// out base ^ exponent mod modulus with exact 64-bit products for each accepted
// word and checks every result strobe against the oldest pending prediction.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_modular_exponentiation;

  localparam int unsigned W = modexp_pkg::DefaultWidth;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam int unsigned SETTLE_CYCLES = 16;

  // Predicted result word
  typedef struct packed {
    logic [W-1:0] value;
    logic         bad;
  } power_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] base_i = '0;
  logic [W-1:0] exponent_i = '0;
  logic [W-1:0] modulus_i = '0;
  logic         valid_o;
  logic [W-1:0] result_o;
  logic         bad_modulus_o;

  power_word_t  pending_powers[$];
  int unsigned  fail_count = 0;
  bit           gaps_on = 1'b1;
  bit           start_high = 1'b0;

  modular_exponentiation #(
    .WIDTH(W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .base_i       (base_i),
    .exponent_i   (exponent_i),
    .modulus_i    (modulus_i),
    .valid_o      (valid_o),
    .result_o     (result_o),
    .bad_modulus_o(bad_modulus_o)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // Square-and-multiply, MSB first; products of two residues fit in 2*W bits
  function automatic power_word_t predict_power(logic [W-1:0] b, logic [W-1:0] e,
                                                logic [W-1:0] m);
    power_word_t      w;
    logic [2*W-1:0]   acc;
    logic [2*W-1:0]   red_base;
    logic [2*W-1:0]   m_wide;
    w.value = '0;
    w.bad   = 1'b0;
    m_wide  = {{W{1'b0}}, m};
    if (m == '0) begin
      w.bad = 1'b1;
    end else if (e == '0) begin
      w.value = W'(1);
    end else begin
      red_base = {{W{1'b0}}, b} % m_wide;
      acc      = 1 % m_wide;
      for (int i = W - 1; i >= 0; i--) begin
        acc = (acc * acc) % m_wide;
        if (e[i]) begin
          acc = (acc * red_base) % m_wide;
        end
      end
      w.value = acc[W-1:0];
    end
    return w;
  endfunction

  // Operand drawn from a mix of corner values and full-range noise
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = W'(1);
      2: v = ALL_ONES;
      3: v = $urandom_range(2, 255);
      4: v = {1'b1, (W-1)'($urandom)};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Send one word, record its prediction, then maybe idle for a burst
  task automatic send_word(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
    start      <= 1'b1;
    start_high  = 1'b1;
    base_i     <= b;
    exponent_i <= e;
    modulus_i  <= m;
    do @(posedge clk_i); while (busy);
    pending_powers.push_back(predict_power(b, e, m));
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start      <= 1'b0;
      start_high  = 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    if (start_high) begin
      start      <= 1'b0;
      start_high  = 1'b0;
    end
  endtask

  // Hold the sender off until every predicted word has come back
  task automatic drain_results();
    stop_sending();
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  // Corner cases: zero modulus, zero exponent, modulus one, extreme operands
  task automatic test_special_cases();
    send_word('0, '0, '0);
    send_word(7, 5, '0);
    send_word(ALL_ONES, ALL_ONES, '0);
    send_word(123, '0, 1);
    send_word(ALL_ONES, '0, ALL_ONES);
    send_word(5, 1, 1);
    send_word(ALL_ONES, ALL_ONES, 1);
    send_word(4, 13, 497);
    send_word('0, 7, 13);
    send_word(1, ALL_ONES, ALL_ONES);
    send_word(ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(ALL_ONES, 2, 32'hFFFF_FFFB);
    send_word(2, 31, ALL_ONES);
    send_word(32'hFFFF_FFFE, ALL_ONES, 32'hFFFF_FFFB);
    send_word(32'h1234_5678, 1, 1000);
    send_word(32'hDEAD_BEEF, 32'h8000_0000, 32'h8000_0000);
    send_word(3, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(7, 32'hFFFF_FFFE, 32'hFFFF_FFFB);
    send_word(3, 1, 2);
  endtask

  // A few words, then a full pause until the block has emptied
  task automatic test_pause_until_drained();
    repeat (3) send_word($urandom, $urandom, $urandom);
    drain_results();
    send_word($urandom, $urandom, $urandom_range(2, 255));
    drain_results();
  endtask

  // Random words: mostly well-formed, some zero modulus / exponent / unit modulus
  task automatic test_random_words(int unsigned count);
    logic [W-1:0] b;
    logic [W-1:0] e;
    logic [W-1:0] m;
    repeat (count) begin
      b = pick_operand();
      e = ($urandom_range(0, 19) == 0) ? '0 : pick_operand();
      case ($urandom_range(0, 19))
        0: m = '0;
        1: m = 1;
        2: m = $urandom_range(2, 64);
        default: m = pick_operand();
      endcase
      send_word(b, e, m);
    end
  endtask

  // Back-to-back words with no idling at all
  task automatic test_back_to_back(int unsigned count);
    gaps_on = 1'b0;
    repeat (count) send_word($urandom, $urandom, $urandom);
  endtask

  // Result checker: each strobe takes the oldest prediction
  always @(posedge clk_i) begin : check_results
    power_word_t want;
    if (rst_ni && valid_o) begin
      if (pending_powers.size() == 0) begin
        $error("result word with none pending: result %0h bad_modulus %0b",
               result_o, bad_modulus_o);
        fail_count++;
      end else begin
        want = pending_powers.pop_front();
        if (result_o !== want.value) begin
          $error("result: expected %0h, actual %0h", want.value, result_o);
          fail_count++;
        end
        if (bad_modulus_o !== want.bad) begin
          $error("bad_modulus: expected %0b, actual %0b", want.bad, bad_modulus_o);
          fail_count++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_special_cases();
    test_pause_until_drained();
    test_random_words(96);
    test_back_to_back(20);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_powers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #80ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
